[src/elevator_call_dispatcher_macros.svh]
// Assertion helpers for the elevator call dispatcher.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef ELEVATOR_CALL_DISPATCHER_MACROS_SVH
`define ELEVATOR_CALL_DISPATCHER_MACROS_SVH

// same-cycle implication
`define ECD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ecd_pkg.sv]
`default_nettype none

package ecd_pkg;

  localparam int unsigned FLOORS_DEFAULT = 10;

  // event codes
  localparam logic [2:0] OP_UP_CALL      = 3'd0;
  localparam logic [2:0] OP_DOWN_CALL    = 3'd1;
  localparam logic [2:0] OP_CAR_CALL     = 3'd2;
  localparam logic [2:0] OP_FLOOR_REACH  = 3'd3;
  localparam logic [2:0] OP_HOLD_TOGGLE  = 3'd4;
  localparam logic [2:0] OP_DOOR_OPENED  = 3'd5;
  localparam logic [2:0] OP_DWELL_DONE   = 3'd6;
  localparam logic [2:0] OP_DOOR_CLOSED  = 3'd7;

  localparam logic [1:0] DIR_DOWN = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_IDLE = 2'd2;

  localparam logic [1:0] MOTOR_NONE = 2'd0;
  localparam logic [1:0] MOTOR_UP   = 2'd1;
  localparam logic [1:0] MOTOR_DOWN = 2'd2;

  localparam logic [1:0] DOOR_NONE  = 2'd0;
  localparam logic [1:0] DOOR_OPEN  = 2'd1;
  localparam logic [1:0] DOOR_CLOSE = 2'd2;
  localparam logic [1:0] DOOR_DWELL = 2'd3;

  localparam logic [1:0] PH_CLOSED  = 2'd0;
  localparam logic [1:0] PH_OPENING = 2'd1;
  localparam logic [1:0] PH_OPEN    = 2'd2;
  localparam logic [1:0] PH_CLOSING = 2'd3;

  typedef struct packed {
    logic [3:0]  position;
    logic [1:0]  direction;
    logic [1:0]  last_direction;
    logic [15:0] car_calls;
    logic [15:0] up_calls;
    logic [15:0] down_calls;
    logic        moving;
    logic [1:0]  door_phase;
    logic        hold;
    logic        door_open;
  } car_state_t;

  typedef struct packed {
    logic [1:0] motor;
    logic [1:0] door;
  } car_cmd_t;

endpackage

`default_nettype wire

[src/ecd_evt_if.sv]
`default_nettype none

interface ecd_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [3:0] call_floor;

  modport source (output valid, output operation, output call_floor, input ready);
  modport sink (input valid, input operation, input call_floor, output ready);
endinterface

`default_nettype wire

[src/ecd_res_if.sv]
`default_nettype none

interface ecd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] motor_command;
  logic [1:0] door_command;
  logic [3:0] car_floor;
  logic [1:0] travel_direction;
  logic       door_busy;
  logic       car_moving;

  modport source (output valid, output motor_command, output door_command,
                  output car_floor, output travel_direction, output door_busy,
                  output car_moving, input ready);
  modport sink (input valid, input motor_command, input door_command,
                input car_floor, input travel_direction, input door_busy,
                input car_moving, output ready);
endinterface

`default_nettype wire

[src/ecd_step.sv]
`default_nettype none

// Next-state logic for one event: event decode, then one dispatch pass,
// then at most one arrival.
module ecd_step #(
  parameter int unsigned FLOORS = ecd_pkg::FLOORS_DEFAULT
) (
  input  logic [2:0]         op_i,
  input  logic [3:0]         floor_i,
  input  ecd_pkg::car_state_t state_i,
  output ecd_pkg::car_state_t state_o,
  output ecd_pkg::car_cmd_t   cmd_o
);

  localparam logic [15:0] FloorMask = 16'((17'd1 << FLOORS) - 17'd1);
  localparam logic [3:0]  TopFloor  = 4'(FLOORS - 1);
  localparam logic [4:0]  FloorsW   = 5'(FLOORS);

  function automatic logic [3:0] lowest_bit(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  function automatic logic [3:0] highest_bit(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  ecd_pkg::car_state_t st;
  logic [1:0]  motor;
  logic [1:0]  door;
  logic [15:0] call_bit;
  logic [15:0] pos_bit;
  logic        do_disp;
  logic        do_arrive;
  logic [15:0] calls;
  logic        free_car;
  logic [16:0] up_span;
  logic [15:0] low_span;
  logic [15:0] ahead;
  logic [15:0] below;
  logic        idle_path;
  logic        go;
  logic [3:0]  target;
  logic [15:0] tgt_bit;

  always_comb begin
    st        = state_i;
    motor     = ecd_pkg::MOTOR_NONE;
    door      = ecd_pkg::DOOR_NONE;
    do_disp   = 1'b0;
    do_arrive = 1'b0;
    call_bit  = ({1'b0, floor_i} < FloorsW) ? (16'd1 << floor_i) : 16'd0;
    pos_bit   = '0;

    unique case (op_i)
      ecd_pkg::OP_UP_CALL: begin
        st.up_calls = st.up_calls | call_bit;
        do_disp     = 1'b1;
      end
      ecd_pkg::OP_DOWN_CALL: begin
        st.down_calls = st.down_calls | call_bit;
        do_disp       = 1'b1;
      end
      ecd_pkg::OP_CAR_CALL: begin
        st.car_calls = st.car_calls | call_bit;
        do_disp      = 1'b1;
      end
      ecd_pkg::OP_FLOOR_REACH: begin
        if (st.moving) begin
          st.moving = 1'b0;
          if (st.direction == ecd_pkg::DIR_UP) begin
            if (st.position < TopFloor) st.position = st.position + 4'd1;
            pos_bit = 16'd1 << st.position;
            if (((st.car_calls | st.up_calls) & pos_bit) != '0) do_arrive = 1'b1;
            else do_disp = 1'b1;
          end else if (st.direction == ecd_pkg::DIR_DOWN) begin
            if (st.position != 4'd0) st.position = st.position - 4'd1;
            pos_bit = 16'd1 << st.position;
            if (((st.car_calls | st.down_calls) & pos_bit) != '0) do_arrive = 1'b1;
            else do_disp = 1'b1;
          end else begin
            do_disp = 1'b1;
          end
        end
      end
      ecd_pkg::OP_HOLD_TOGGLE: begin
        st.hold = ~st.hold;
        if (st.hold) begin
          if (st.door_phase == ecd_pkg::PH_CLOSING) st.door_phase = ecd_pkg::PH_OPEN;
          if (!st.moving) begin
            door          = ecd_pkg::DOOR_OPEN;
            st.door_phase = ecd_pkg::PH_OPENING;
          end
        end else if (!st.moving) begin
          door          = ecd_pkg::DOOR_CLOSE;
          st.door_phase = ecd_pkg::PH_CLOSING;
        end
      end
      ecd_pkg::OP_DOOR_OPENED: begin
        if (st.door_phase == ecd_pkg::PH_OPENING) begin
          st.door_phase = ecd_pkg::PH_OPEN;
          if (!st.hold) door = ecd_pkg::DOOR_DWELL;
        end
      end
      ecd_pkg::OP_DWELL_DONE: begin
        if (!st.moving && !st.hold) begin
          door          = ecd_pkg::DOOR_CLOSE;
          st.door_phase = ecd_pkg::PH_CLOSING;
        end
      end
      ecd_pkg::OP_DOOR_CLOSED: begin
        if (st.door_phase == ecd_pkg::PH_CLOSING) begin
          st.door_phase = ecd_pkg::PH_CLOSED;
          st.door_open  = 1'b0;
          do_disp       = 1'b1;
        end
      end
    endcase

    // dispatch pass
    calls     = (st.car_calls | st.up_calls | st.down_calls) & FloorMask;
    free_car  = !st.moving && !st.door_open;
    up_span   = (17'd2 << st.position) - 17'd1;
    low_span  = (16'd1 << st.position) - 16'd1;
    ahead     = calls & ~up_span[15:0];
    below     = calls & low_span;
    idle_path = 1'b0;
    go        = 1'b0;
    target    = '0;
    if (do_disp) begin
      if (st.direction == ecd_pkg::DIR_UP) begin
        if (ahead != '0) begin
          go     = free_car;
          target = lowest_bit(ahead);
        end else begin
          st.direction      = ecd_pkg::DIR_IDLE;
          st.last_direction = ecd_pkg::DIR_UP;
          idle_path         = 1'b1;
        end
      end else if (st.direction == ecd_pkg::DIR_DOWN) begin
        if (below != '0) begin
          go     = free_car;
          target = highest_bit(below);
        end else begin
          st.direction      = ecd_pkg::DIR_IDLE;
          st.last_direction = ecd_pkg::DIR_DOWN;
          idle_path         = 1'b1;
        end
      end else begin
        idle_path = 1'b1;
      end
      if (idle_path) begin
        st.direction = ecd_pkg::DIR_IDLE;
        go           = (calls != '0) && free_car;
        target       = (st.last_direction == ecd_pkg::DIR_UP) ? highest_bit(calls)
                                                               : lowest_bit(calls);
      end
    end

    // start a move, or serve the current floor
    tgt_bit = 16'd1 << target;
    if (go) begin
      if (target > st.position) begin
        st.direction = ecd_pkg::DIR_UP;
        st.moving    = 1'b1;
        motor        = ecd_pkg::MOTOR_UP;
      end else if (target < st.position) begin
        st.direction = ecd_pkg::DIR_DOWN;
        st.moving    = 1'b1;
        motor        = ecd_pkg::MOTOR_DOWN;
      end else begin
        if ((st.up_calls & tgt_bit) != '0) st.direction = ecd_pkg::DIR_UP;
        else if ((st.down_calls & tgt_bit) != '0) st.direction = ecd_pkg::DIR_DOWN;
        do_arrive = 1'b1;
      end
    end

    if (do_arrive) begin
      pos_bit      = 16'd1 << st.position;
      st.car_calls = st.car_calls & ~pos_bit;
      st.door_open = 1'b1;
      if (st.direction == ecd_pkg::DIR_DOWN) st.down_calls = st.down_calls & ~pos_bit;
      if (st.direction == ecd_pkg::DIR_UP) st.up_calls = st.up_calls & ~pos_bit;
      if (st.door_phase == ecd_pkg::PH_CLOSING) st.door_phase = ecd_pkg::PH_OPEN;
      if (!st.moving) begin
        door          = ecd_pkg::DOOR_OPEN;
        st.door_phase = ecd_pkg::PH_OPENING;
      end
    end
  end

  assign state_o   = st;
  assign cmd_o.motor = motor;
  assign cmd_o.door  = door;

endmodule

`default_nettype wire

[src/elevator_call_dispatcher.sv]
// Single-car collective-control dispatcher.
// evt_i carries one event word per handshake: operation (up, down or car
// call, floor reached, hold toggle, door opened, dwell expired, door
// closed) and call_floor. res_o returns exactly one word per event: motor
// and door commands plus car floor, travel direction, door busy and moving.
// An event word is taken into an input register; the call search and state
// update then run in one combinational pass, and the result lands in the
// output register when that is empty or being read. res_o.valid rises as
// the output register loads. Throughput is one event per cycle while
// res_o.ready stays high, set by that single pass.
// A held result does not block intake: the input register still takes one
// more word, and evt_i.ready drops only while both registers are full and
// res_o.ready is low. Nothing is lost or reordered under stalls.
// Reset puts the car idle at floor 0 with the door closed, no calls
// pending and hold off; both registers come out of reset empty.
`default_nettype none
`include "elevator_call_dispatcher_macros.svh"

module elevator_call_dispatcher #(
  parameter int unsigned FLOORS = ecd_pkg::FLOORS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ecd_evt_if.sink          evt_i,
  ecd_res_if.source        res_o
);

  logic                s1_valid_q;
  logic [2:0]          s1_op_q;
  logic [3:0]          s1_floor_q;
  ecd_pkg::car_state_t state_q;
  ecd_pkg::car_state_t state_d;
  ecd_pkg::car_cmd_t   cmd_d;
  logic                out_valid_q;
  ecd_pkg::car_cmd_t   out_cmd_q;
  ecd_pkg::car_state_t out_state_q;
  logic                advance;
  logic                take;

  assign advance     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !s1_valid_q || advance;
  assign take        = evt_i.valid && evt_i.ready;

  ecd_step #(
    .FLOORS (FLOORS)
  ) u_step (
    .op_i    (s1_op_q),
    .floor_i (s1_floor_q),
    .state_i (state_q),
    .state_o (state_d),
    .cmd_o   (cmd_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{position: 4'd0, direction: ecd_pkg::DIR_IDLE,
                       last_direction: ecd_pkg::DIR_IDLE, car_calls: 16'd0,
                       up_calls: 16'd0, down_calls: 16'd0, moving: 1'b0,
                       door_phase: ecd_pkg::PH_CLOSED, hold: 1'b0,
                       door_open: 1'b0};
    end else begin
      if (take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_op_q    <= evt_i.operation;
      s1_floor_q <= evt_i.call_floor;
    end
    if (advance) begin
      out_cmd_q   <= cmd_d;
      out_state_q <= state_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.motor_command    = out_cmd_q.motor;
  assign res_o.door_command     = out_cmd_q.door;
  assign res_o.car_floor        = out_state_q.position;
  assign res_o.travel_direction = out_state_q.direction;
  assign res_o.door_busy        = out_state_q.door_open;
  assign res_o.car_moving       = out_state_q.moving;

  `ECD_ASSERT_NOW(a_no_move_with_door, state_q.moving, !state_q.door_open, "car moving with door busy")
  `ECD_ASSERT_NOW(a_floor_range, 1'b1, state_q.position <= 4'(FLOORS - 1), "car floor out of range")
  `ECD_ASSERT_NOW(a_motor_sets_moving, out_valid_q && (out_cmd_q.motor != ecd_pkg::MOTOR_NONE), out_state_q.moving, "motor start without moving")
  `ECD_ASSERT_NEXT(a_advance_result, advance, out_valid_q, "result register not loaded")

endmodule

`default_nettype wire

[tb/sv/car_dispatch_checker.sv]
`timescale 1ns / 1ps

// Watches the event and result channels, keeps a shadow copy of the car,
// and checks each result word against the shadow's prediction.
module car_dispatch_checker
  import ecd_pkg::*;
#(
  parameter int unsigned FLOORS = FLOORS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  ecd_evt_if   evt_i,
  ecd_res_if   res_i,
  output int   fail_count_o,
  output int   effective_o,
  output int   checked_o,
  output int   starts_o,
  output int   arrivals_o,
  output int   pending_o
);

  localparam logic [15:0] FLOOR_MASK = 16'((32'd1 << FLOORS) - 32'd1);

  typedef struct packed {
    logic [1:0] motor;
    logic [1:0] door;
    logic [3:0] floor_no;
    logic [1:0] dir;
    logic       busy;
    logic       moving;
  } car_word_t;

  car_state_t car;
  logic [1:0] motor_cmd;
  logic [1:0] door_cmd;
  car_word_t  car_words_due[$];

  function automatic logic [3:0] lowest_call(input logic [15:0] v);
    for (int i = 0; i < 16; i++)
      if (v[i]) return 4'(i);
    return 4'd0;
  endfunction

  function automatic logic [3:0] highest_call(input logic [15:0] v);
    for (int i = 15; i >= 0; i--)
      if (v[i]) return 4'(i);
    return 4'd0;
  endfunction

  function automatic void request_open();
    if (car.door_phase == PH_CLOSING) car.door_phase = PH_OPEN;
    if (!car.moving) begin
      door_cmd = DOOR_OPEN;
      car.door_phase = PH_OPENING;
    end
  endfunction

  function automatic void request_close();
    if (!car.moving && !car.hold) begin
      door_cmd = DOOR_CLOSE;
      car.door_phase = PH_CLOSING;
    end
  endfunction

  function automatic void serve_floor();
    car.car_calls[car.position] = 1'b0;
    car.door_open = 1'b1;
    if (car.direction == DIR_DOWN) car.down_calls[car.position] = 1'b0;
    if (car.direction == DIR_UP) car.up_calls[car.position] = 1'b0;
    arrivals_o++;
    request_open();
  endfunction

  function automatic void head_to(input logic [3:0] target);
    if (target > car.position) begin
      car.direction = DIR_UP;
      car.moving = 1'b1;
      motor_cmd = MOTOR_UP;
    end else if (target < car.position) begin
      car.direction = DIR_DOWN;
      car.moving = 1'b1;
      motor_cmd = MOTOR_DOWN;
    end else begin
      // already here: pick up the hall call's direction, up first
      if (car.up_calls[target]) car.direction = DIR_UP;
      else if (car.down_calls[target]) car.direction = DIR_DOWN;
      serve_floor();
    end
  endfunction

  function automatic void dispatch_car();
    logic [15:0] calls;
    logic        free_car;
    logic [31:0] ahead;
    logic [31:0] below;
    calls = (car.car_calls | car.up_calls | car.down_calls) & FLOOR_MASK;
    free_car = !car.moving && !car.door_open;
    ahead = {16'd0, calls} & ~((32'd2 << car.position) - 32'd1);
    below = {16'd0, calls} & ((32'd1 << car.position) - 32'd1);
    if (car.direction == DIR_UP) begin
      if (ahead != 0) begin
        if (free_car) head_to(lowest_call(ahead[15:0]));
        return;
      end
      car.direction = DIR_IDLE;
      car.last_direction = DIR_UP;
    end else if (car.direction == DIR_DOWN) begin
      if (below != 0) begin
        if (free_car) head_to(highest_call(below[15:0]));
        return;
      end
      car.direction = DIR_IDLE;
      car.last_direction = DIR_DOWN;
    end
    car.direction = DIR_IDLE;
    if (calls != 0 && free_car)
      head_to(car.last_direction == DIR_UP ? highest_call(calls) : lowest_call(calls));
  endfunction

  function automatic void reach_floor();
    logic stop_here;
    if (!car.moving) return;
    car.moving = 1'b0;
    if (car.direction == DIR_UP) begin
      if (car.position < FLOORS - 1) car.position = car.position + 4'd1;
      stop_here = car.car_calls[car.position] | car.up_calls[car.position];
    end else if (car.direction == DIR_DOWN) begin
      if (car.position > 0) car.position = car.position - 4'd1;
      stop_here = car.car_calls[car.position] | car.down_calls[car.position];
    end else begin
      stop_here = 1'b0;
    end
    if (stop_here) serve_floor();
    else dispatch_car();
  endfunction

  function automatic car_word_t advance_car(input logic [2:0] op, input logic [3:0] fl);
    car_state_t prior;
    logic       in_range;
    prior = car;
    in_range = (fl < FLOORS);
    motor_cmd = MOTOR_NONE;
    door_cmd = DOOR_NONE;
    case (op)
      OP_UP_CALL: begin
        if (in_range) car.up_calls[fl] = 1'b1;
        dispatch_car();
      end
      OP_DOWN_CALL: begin
        if (in_range) car.down_calls[fl] = 1'b1;
        dispatch_car();
      end
      OP_CAR_CALL: begin
        if (in_range) car.car_calls[fl] = 1'b1;
        dispatch_car();
      end
      OP_FLOOR_REACH: reach_floor();
      OP_HOLD_TOGGLE: begin
        car.hold = !car.hold;
        if (car.hold) request_open();
        else request_close();
      end
      OP_DOOR_OPENED: begin
        if (car.door_phase == PH_OPENING) begin
          car.door_phase = PH_OPEN;
          if (!car.hold) door_cmd = DOOR_DWELL;
        end
      end
      OP_DWELL_DONE: request_close();
      OP_DOOR_CLOSED: begin
        if (car.door_phase == PH_CLOSING) begin
          car.door_phase = PH_CLOSED;
          car.door_open = 1'b0;
          dispatch_car();
        end
      end
      default: ;
    endcase
    if (car != prior || motor_cmd != MOTOR_NONE || door_cmd != DOOR_NONE) effective_o++;
    if (motor_cmd != MOTOR_NONE) starts_o++;
    return {motor_cmd, door_cmd, car.position, car.direction, car.door_open, car.moving};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    car_word_t got;
    car_word_t want;
    if (!rst_ni) begin
      car = '0;
      car.direction = DIR_IDLE;
      car.last_direction = DIR_IDLE;
      car_words_due.delete();
      fail_count_o = 0;
      effective_o = 0;
      checked_o = 0;
      starts_o = 0;
      arrivals_o = 0;
      pending_o = 0;
    end else begin
      // result side first: a word accepted this edge cannot answer one taken now
      if (res_i.valid && res_i.ready) begin
        got = {res_i.motor_command, res_i.door_command, res_i.car_floor,
               res_i.travel_direction, res_i.door_busy, res_i.car_moving};
        if (car_words_due.size() == 0) begin
          $display("%0t: unexpected result word motor=%0d door=%0d floor=%0d dir=%0d",
                   $time, got.motor, got.door, got.floor_no, got.dir);
          fail_count_o++;
        end else begin
          want = car_words_due.pop_front();
          if (got !== want) begin
            $display("%0t: word %0d expected motor=%0d door=%0d floor=%0d dir=%0d busy=%0b mov=%0b",
                     $time, checked_o, want.motor, want.door, want.floor_no, want.dir,
                     want.busy, want.moving);
            $display("%0t: word %0d actual   motor=%0d door=%0d floor=%0d dir=%0d busy=%0b mov=%0b",
                     $time, checked_o, got.motor, got.door, got.floor_no, got.dir,
                     got.busy, got.moving);
            fail_count_o++;
          end
          checked_o++;
        end
      end
      if (evt_i.valid && evt_i.ready) begin
        want = advance_car(evt_i.operation, evt_i.call_floor);
        car_words_due = {car_words_due, want};
      end
      pending_o = car_words_due.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ecd_pkg::*;

  localparam int unsigned FLOORS = FLOORS_DEFAULT;
  localparam int EVENT_TARGET = 950;
  localparam int STUCK_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;
  int   sent;
  int   stuck;
  int   fails, effective, checked, starts, arrivals, pending;

  ecd_evt_if evt ();
  ecd_res_if res ();

  elevator_call_dispatcher #(.FLOORS(FLOORS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt.sink),
    .res_o  (res.source)
  );

  car_dispatch_checker #(.FLOORS(FLOORS)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt),
    .res_i        (res),
    .fail_count_o (fails),
    .effective_o  (effective),
    .checked_o    (checked),
    .starts_o     (starts),
    .arrivals_o   (arrivals),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // a stretch of words with no idling on either side
  function automatic logic quiet_span();
    return sent >= 300 && sent < 520;
  endfunction

  function automatic logic [3:0] pick_floor();
    if ($urandom_range(0, 99) < 82) return 4'($urandom_range(0, FLOORS - 1));
    return 4'($urandom_range(FLOORS, 15));
  endfunction

  task automatic put_word(input logic [2:0] op, input logic [3:0] fl);
    while (!quiet_span() && $urandom_range(0, 99) < 11) begin
      evt.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt.valid <= 1'b1;
    evt.operation <= op;
    evt.call_floor <= fl;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (evt.valid && evt.ready) || (res.valid && res.ready)) stuck <= 0;
    else stuck <= stuck + 1;
  end

  initial begin
    wait (stuck >= STUCK_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
    $display("[elevator_call_dispatcher] ERROR");
    $finish;
  end

  initial begin
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      res.ready <= quiet_span() || $urandom_range(0, 99) >= 11;
    end
  end

  initial begin
    int pick;
    int n;
    sent = 0;
    rst_ni = 1'b0;
    evt.valid = 1'b0;
    evt.operation = OP_UP_CALL;
    evt.call_floor = 4'd0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // up call at the current floor while idle, then a full door cycle
    put_word(OP_UP_CALL, 4'd0);
    put_word(OP_DOOR_OPENED, 4'd0);
    put_word(OP_DWELL_DONE, 4'd0);
    put_word(OP_DOOR_CLOSED, 4'd0);
    // out-of-range calls are dropped but still dispatch
    put_word(OP_CAR_CALL, 4'd15);
    put_word(OP_UP_CALL, 4'(FLOORS));
    put_word(OP_DOWN_CALL, 4'd1);
    put_word(OP_CAR_CALL, 4'(FLOORS - 1));
    put_word(OP_FLOOR_REACH, 4'd0);
    // hold while moving: no door command either way
    put_word(OP_HOLD_TOGGLE, 4'd0);
    put_word(OP_HOLD_TOGGLE, 4'd0);
    for (int i = 0; i < FLOORS - 2; i++) put_word(OP_FLOOR_REACH, 4'(i));
    put_word(OP_FLOOR_REACH, 4'd15);
    // hold at the top floor: open without dwell, dwell blocked, then release
    put_word(OP_HOLD_TOGGLE, 4'd0);
    put_word(OP_DOOR_OPENED, 4'd0);
    put_word(OP_DWELL_DONE, 4'd0);
    put_word(OP_HOLD_TOGGLE, 4'd0);
    put_word(OP_DOOR_CLOSED, 4'd0);

    while (sent < EVENT_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        n = $urandom_range(1, 3);
        repeat (n) put_word(3'($urandom_range(OP_UP_CALL, OP_CAR_CALL)), pick_floor());
      end else if (pick < 55) begin
        n = $urandom_range(1, 4);
        repeat (n) put_word(OP_FLOOR_REACH, 4'($urandom_range(0, 15)));
      end else if (pick < 85) begin
        put_word(OP_DOOR_OPENED, 4'($urandom_range(0, 15)));
        put_word(OP_DWELL_DONE, 4'($urandom_range(0, 15)));
        put_word(OP_DOOR_CLOSED, 4'($urandom_range(0, 15)));
      end else if (pick < 92) begin
        put_word(OP_HOLD_TOGGLE, 4'($urandom_range(0, 15)));
        put_word(OP_DOOR_OPENED, 4'($urandom_range(0, 15)));
        put_word(OP_HOLD_TOGGLE, 4'($urandom_range(0, 15)));
      end else begin
        put_word(3'($urandom_range(OP_UP_CALL, OP_DOOR_CLOSED)), 4'($urandom_range(0, 15)));
      end
    end
    evt.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("sent %0d event words (%0d changed the car), checked %0d result words",
             sent, effective, checked);
    $display("car made %0d motor starts and %0d floor arrivals", starts, arrivals);
    if (fails == 0) begin
      $display("[elevator_call_dispatcher] OK");
    end else begin
      $display("%0d mismatching words", fails);
      $display("[elevator_call_dispatcher] ERROR");
    end
    $finish;
  end

endmodule

[elevator_call_dispatcher.f]
+incdir+src
src/ecd_pkg.sv
src/ecd_evt_if.sv
src/ecd_res_if.sv
src/ecd_step.sv
src/elevator_call_dispatcher.sv
tb/sv/car_dispatch_checker.sv
tb/sv/testbench.sv
